// ----- src/rrbm_pkg.sv -----
`timescale 1ns / 1ps
// rrbm_pkg: shared types, codes and helper functions of the bank mapper with clock
// no dependencies

package rrbm_pkg;

    localparam int RAM_BYTES_DEF     = 32768;
    localparam int ROM_BANK_BITS_DEF = 7;

    localparam int ROM_ADDR_W  = 22;
    localparam int RAM_SIZE_W  = 16;
    localparam int CFG_DATA_W  = 22;

    localparam logic [15:0] ROM_BANK_SPAN  = 16'h4000;
    localparam logic [15:0] RAM_ENABLE_TOP = 16'h1FFF;
    localparam logic [15:0] ROM_BANK_TOP   = 16'h3FFF;
    localparam logic [15:0] SELECT_TOP     = 16'h5FFF;
    localparam logic [15:0] RAM_WINDOW     = 16'hA000;
    localparam logic [3:0]  RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0]  OPEN_BUS       = 8'hFF;
    localparam logic [7:0]  CLOCK_SEL_LO   = 8'h08;
    localparam logic [7:0]  CLOCK_SEL_HI   = 8'h0C;

    typedef enum logic [2:0] {
        ACT_ROM_READ  = 3'd0,
        ACT_ROM_WRITE = 3'd1,
        ACT_RAM_READ  = 3'd2,
        ACT_RAM_WRITE = 3'd3,
        ACT_TICK      = 3'd4
    } action_t;

    typedef enum logic {
        CFG_ROM_SIZE = 1'b0,
        CFG_RAM_SIZE = 1'b1
    } cfg_index_t;

    localparam logic [2:0] RTC_SECONDS = 3'd0;
    localparam logic [2:0] RTC_MINUTES = 3'd1;
    localparam logic [2:0] RTC_HOURS   = 3'd2;
    localparam logic [2:0] RTC_DAY_LO  = 3'd3;
    localparam logic [2:0] RTC_CONTROL = 3'd4;
    localparam int         RTC_REGS    = 5;

    typedef struct packed {
        logic       tick;
        logic       write;
        logic       latch;
        logic [2:0] idx;
        logic [7:0] data;
    } rtc_ctrl_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
    } result_t;

    // v mod 60 through a reciprocal multiply on v/4
    function automatic logic [5:0] mod60(input logic [7:0] v);
        logic [12:0] prod;
        logic [7:0]  q60;
        logic [7:0]  r;
        prod = 13'(v[7:2]) * 13'd69;
        q60  = 8'(prod[12:10]) * 8'd60;
        r    = v - q60;
        return r[5:0];
    endfunction

    // v mod 24 through a reciprocal multiply on v/8
    function automatic logic [4:0] mod24(input logic [7:0] v);
        logic [8:0] prod;
        logic [7:0] q24;
        logic [7:0] r;
        prod = 9'(v[7:3]) * 9'd11;
        q24  = 8'(prod[8:5]) * 8'd24;
        r    = v - q24;
        return r[4:0];
    endfunction

endpackage

// ----- src/rrbm_ram.sv -----
`timescale 1ns / 1ps
// rrbm_ram: generic single-port synchronous RAM with registered read data
// no dependencies

module rrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/rrbm_rtc.sv -----
`timescale 1ns / 1ps
// rrbm_rtc: live clock counters, latched copy and clock register read mux
// depends on rrbm_pkg

module rrbm_rtc (
    input  logic               aclk,
    input  logic               aresetn,
    input  rrbm_pkg::rtc_ctrl_t ctrl,
    output logic [7:0]         rd_data
);

    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [8:0] day_reg, day_next;
    logic       halt_reg, halt_next;
    logic       carry_reg, carry_next;
    logic       taken_reg, taken_next;
    logic [7:0] latched_reg [rrbm_pkg::RTC_REGS];
    logic [7:0] live [rrbm_pkg::RTC_REGS];

    always_comb begin
        live[0] = {2'b00, sec_reg};
        live[1] = {2'b00, min_reg};
        live[2] = {3'b000, hour_reg};
        live[3] = day_reg[7:0];
        live[4] = {carry_reg, halt_reg, 5'b00000, day_reg[8]};
    end

    always_comb begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        halt_next  = halt_reg;
        carry_next = carry_reg;
        taken_next = taken_reg;
        if (ctrl.latch) begin
            taken_next = 1'b1;
        end
        if (ctrl.write) begin
            case (ctrl.idx)
                rrbm_pkg::RTC_SECONDS: sec_next  = rrbm_pkg::mod60(ctrl.data);
                rrbm_pkg::RTC_MINUTES: min_next  = rrbm_pkg::mod60(ctrl.data);
                rrbm_pkg::RTC_HOURS:   hour_next = rrbm_pkg::mod24(ctrl.data);
                rrbm_pkg::RTC_DAY_LO:  day_next  = {day_reg[8], ctrl.data};
                rrbm_pkg::RTC_CONTROL: begin
                    day_next   = {ctrl.data[0], day_reg[7:0]};
                    halt_next  = ctrl.data[6];
                    carry_next = ctrl.data[7];
                end
                default: ;
            endcase
        end
        if (ctrl.tick && !halt_reg) begin
            if (sec_reg != 6'd59) begin
                sec_next = sec_reg + 6'd1;
            end else begin
                sec_next = '0;
                if (min_reg != 6'd59) begin
                    min_next = min_reg + 6'd1;
                end else begin
                    min_next = '0;
                    if (hour_reg != 5'd23) begin
                        hour_next = hour_reg + 5'd1;
                    end else begin
                        hour_next = '0;
                        day_next  = day_reg + 9'd1;
                        if (day_reg == 9'h1FF) begin
                            carry_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= '0;
            halt_reg  <= 1'b0;
            carry_reg <= 1'b0;
            taken_reg <= 1'b0;
            for (int i = 0; i < rrbm_pkg::RTC_REGS; i++) begin
                latched_reg[i] <= '0;
            end
        end else begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            halt_reg  <= halt_next;
            carry_reg <= carry_next;
            taken_reg <= taken_next;
            if (ctrl.latch) begin
                for (int i = 0; i < rrbm_pkg::RTC_REGS; i++) begin
                    latched_reg[i] <= live[i];
                end
            end
        end
    end

    always_comb begin
        case (ctrl.idx)
            rrbm_pkg::RTC_SECONDS,
            rrbm_pkg::RTC_MINUTES,
            rrbm_pkg::RTC_HOURS,
            rrbm_pkg::RTC_DAY_LO,
            rrbm_pkg::RTC_CONTROL: rd_data = taken_reg ? latched_reg[ctrl.idx]
                                                       : live[ctrl.idx];
            default:               rd_data = rrbm_pkg::OPEN_BUS;
        endcase
    end

endmodule

// ----- src/rom_ram_bank_mapper_with_rtc_core.sv -----
`timescale 1ns / 1ps
// rom_ram_bank_mapper_with_rtc_core: top level of the cartridge bank mapper with clock
// depends on rrbm_pkg, rrbm_ram, rrbm_rtc

// Cartridge bank mapper with a real-time clock. Takes one bus access or one-second
// tick per cycle on the s_ channel while s_ready is high and returns exactly one
// result per item on the m_ channel, in order. Each item passes the registered read
// port of the cart RAM, then the output queue; sustained throughput is one item per
// cycle while m_ready keeps up. Bank, select and clock state change at the edge that
// accepts an item. A four-entry output queue lets input keep flowing while results
// wait. Cart RAM is not cleared at reset; no clearing pass is run. Size registers must
// be written through cfg_we/cfg_index/cfg_data while idle; the block does not check it.
module rom_ram_bank_mapper_with_rtc_core #(
    parameter int RAM_BYTES     = rrbm_pkg::RAM_BYTES_DEF,
    parameter int ROM_BANK_BITS = rrbm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rrbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_action,
    input  logic [15:0]                       s_address,
    input  logic [7:0]                        s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_read_data,
    output logic                              m_rom_fetch,
    output logic [rrbm_pkg::ROM_ADDR_W-1:0]   m_rom_address
);

    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    logic [rrbm_pkg::ROM_ADDR_W-1:0] rom_size_reg;
    logic [rrbm_pkg::RAM_SIZE_W-1:0] ram_size_reg;

    logic [ROM_BANK_BITS-1:0] rom_bank_reg, rom_bank_next;
    logic                     ram_en_reg, ram_en_next;
    logic [7:0]               select_reg, select_next;
    logic [7:0]               last_latch_reg, last_latch_next;

    logic                      accept;
    logic [rrbm_pkg::ROM_ADDR_W-1:0] rom_off;
    logic                      rom_hit;
    logic                      clock_sel;
    logic [16:0]               ram_off;
    logic                      ram_hit;
    logic                      ram_we;
    logic [7:0]                ram_rdata;
    logic [7:0]                rtc_rdata;
    rrbm_pkg::rtc_ctrl_t       rtc_ctrl;
    rrbm_pkg::result_t         res;
    logic                      use_ram;

    logic                      p1_valid_reg;
    logic                      p1_use_ram_reg;
    rrbm_pkg::result_t         p1_res_reg;
    rrbm_pkg::result_t         p1_out;

    rrbm_pkg::result_t         fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          pending;
    logic                      pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_size_reg <= rrbm_pkg::ROM_ADDR_W'(2097152);
            ram_size_reg <= rrbm_pkg::RAM_SIZE_W'(32768);
        end else if (cfg_we) begin
            case (cfg_index)
                rrbm_pkg::CFG_ROM_SIZE: rom_size_reg <= cfg_data;
                rrbm_pkg::CFG_RAM_SIZE: ram_size_reg <= cfg_data[rrbm_pkg::RAM_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign pending = cnt_reg + CNT_W'(p1_valid_reg);
    assign s_ready = pending < CNT_W'(FIFO_DEPTH);
    assign accept  = s_valid && s_ready;

    // address decode
    always_comb begin
        if (s_address < rrbm_pkg::ROM_BANK_SPAN) begin
            rom_off = rrbm_pkg::ROM_ADDR_W'(s_address);
        end else begin
            rom_off = (rrbm_pkg::ROM_ADDR_W'(rom_bank_reg) << 14)
                    + rrbm_pkg::ROM_ADDR_W'(s_address - rrbm_pkg::ROM_BANK_SPAN);
        end
        rom_hit   = rom_off < rom_size_reg;
        clock_sel = (select_reg >= rrbm_pkg::CLOCK_SEL_LO)
                 && (select_reg <= rrbm_pkg::CLOCK_SEL_HI);
        ram_off   = {select_reg[1:0], 15'd0} >> 2;
        ram_off   = ram_off + 17'(s_address - rrbm_pkg::RAM_WINDOW);
        ram_hit   = (s_address >= rrbm_pkg::RAM_WINDOW)
                 && (ram_off < 17'(ram_size_reg))
                 && (ram_off < 17'(RAM_BYTES));
    end

    always_comb begin
        rom_bank_next   = rom_bank_reg;
        ram_en_next     = ram_en_reg;
        select_next     = select_reg;
        last_latch_next = last_latch_reg;
        rtc_ctrl.tick   = 1'b0;
        rtc_ctrl.write  = 1'b0;
        rtc_ctrl.latch  = 1'b0;
        rtc_ctrl.idx    = select_reg[2:0];
        rtc_ctrl.data   = s_data;
        ram_we          = 1'b0;
        res             = '0;
        use_ram         = 1'b0;
        case (s_action)
            rrbm_pkg::ACT_ROM_READ: begin
                if (rom_hit) begin
                    res.rom_fetch   = 1'b1;
                    res.rom_address = rom_off;
                end else begin
                    res.read_data = rrbm_pkg::OPEN_BUS;
                end
            end
            rrbm_pkg::ACT_ROM_WRITE: begin
                if (accept) begin
                    if (s_address <= rrbm_pkg::RAM_ENABLE_TOP) begin
                        ram_en_next = s_data[3:0] == rrbm_pkg::RAM_ENABLE_KEY;
                    end else if (s_address <= rrbm_pkg::ROM_BANK_TOP) begin
                        rom_bank_next = (s_data[ROM_BANK_BITS-1:0] == '0)
                                      ? ROM_BANK_BITS'(1) : s_data[ROM_BANK_BITS-1:0];
                    end else if (s_address <= rrbm_pkg::SELECT_TOP) begin
                        select_next = s_data;
                    end else begin
                        rtc_ctrl.latch  = (last_latch_reg == 8'd0) && (s_data == 8'd1);
                        last_latch_next = s_data;
                    end
                end
            end
            rrbm_pkg::ACT_RAM_READ: begin
                if (!ram_en_reg) begin
                    res.read_data = rrbm_pkg::OPEN_BUS;
                end else if (clock_sel) begin
                    res.read_data = rtc_rdata;
                end else if (ram_hit) begin
                    use_ram = 1'b1;
                end else begin
                    res.read_data = rrbm_pkg::OPEN_BUS;
                end
            end
            rrbm_pkg::ACT_RAM_WRITE: begin
                if (accept && ram_en_reg) begin
                    rtc_ctrl.write = clock_sel;
                    ram_we         = !clock_sel && ram_hit;
                end
            end
            rrbm_pkg::ACT_TICK: begin
                rtc_ctrl.tick = accept;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg   <= ROM_BANK_BITS'(1);
            ram_en_reg     <= 1'b0;
            select_reg     <= '0;
            last_latch_reg <= '0;
        end else begin
            rom_bank_reg   <= rom_bank_next;
            ram_en_reg     <= ram_en_next;
            select_reg     <= select_next;
            last_latch_reg <= last_latch_next;
        end
    end

    rrbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_cart_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_off[RAM_AW-1:0]),
        .wdata (s_data),
        .rdata (ram_rdata)
    );

    rrbm_rtc u_rtc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rtc_ctrl),
        .rd_data (rtc_rdata)
    );

    // stage behind the RAM read port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_use_ram_reg <= use_ram;
            p1_res_reg     <= res;
        end
    end

    always_comb begin
        p1_out = p1_res_reg;
        if (p1_use_ram_reg) begin
            p1_out.read_data = ram_rdata;
        end
    end

    // output queue
    assign pop     = m_valid && m_ready;
    assign m_valid = cnt_reg != '0;

    always_comb begin
        cnt_next = cnt_reg;
        if (p1_valid_reg && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!p1_valid_reg && pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (p1_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            fifo_reg[wr_ptr_reg] <= p1_out;
        end
    end

    assign m_read_data   = fifo_reg[rd_ptr_reg].read_data;
    assign m_rom_fetch   = fifo_reg[rd_ptr_reg].rom_fetch;
    assign m_rom_address = fifo_reg[rd_ptr_reg].rom_address;

endmodule
